### rtl/gxdc_pkg.sv
// Shared constants, types and pixel conversion functions of the texture
// detiler. Used by every module of the block; depends on nothing.
`default_nettype none
package gxdc_pkg;

	localparam int PAL_DEPTH = 4096;
	localparam int PAL_AW    = $clog2(PAL_DEPTH);
	localparam int MAX_DIM   = 1024;
	localparam int DIM_W     = 11;
	localparam int IDX_W     = 20;
	localparam int ADDR_W    = 4;

	localparam logic [3:0] FMT_I4     = 4'd0;
	localparam logic [3:0] FMT_I8     = 4'd1;
	localparam logic [3:0] FMT_I4A4   = 4'd2;
	localparam logic [3:0] FMT_I8A8   = 4'd3;
	localparam logic [3:0] FMT_R5G6B5 = 4'd4;
	localparam logic [3:0] FMT_RGB5A3 = 4'd5;
	localparam logic [3:0] FMT_RGBA8  = 4'd6;
	localparam logic [3:0] FMT_IDX4   = 4'd8;
	localparam logic [3:0] FMT_IDX8   = 4'd9;
	localparam logic [3:0] FMT_IDX14  = 4'd10;
	localparam logic [3:0] FMT_DXT1   = 4'd14;

	localparam logic [1:0] PFMT_RGB5A3 = 2'd2;

	localparam logic [1:0] REG_FORMAT  = 2'd0;
	localparam logic [1:0] REG_WIDTH   = 2'd1;
	localparam logic [1:0] REG_HEIGHT  = 2'd2;
	localparam logic [1:0] REG_PALFMT  = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_UNSUP  = 2'd1;
	localparam logic [1:0] ST_PALIDX = 2'd2;

	// Per-request work description handed from the tile walker.
	typedef struct packed {
		logic [11:0] mrow;
		logic [11:0] mwid;
		logic [12:0] mcol;
		logic [3:0]  mask;
		logic [1:0]  last_k;
		logic        dxt;
		logic [1:0]  cit;
		logic        unsup;
		logic        pass;
	} walk_t;

	function automatic logic [31:0] conv_rgb5a3(input logic [15:0] p);
		logic [7:0] a, r, g, b;
		if (p[15]) begin
			a = 8'hff;
			r = {p[14:10], p[14:12]};
			g = {p[9:5], p[9:7]};
			b = {p[4:0], p[4:2]};
		end else begin
			a = {p[14:12], p[14:12], p[14:13]};
			r = {p[11:8], p[11:8]};
			g = {p[7:4], p[7:4]};
			b = {p[3:0], p[3:0]};
		end
		return {a, r, g, b};
	endfunction

	function automatic logic [7:0] rev_pairs(input logic [7:0] b);
		return {b[1:0], b[3:2], b[5:4], b[7:6]};
	endfunction

endpackage
`default_nettype wire

### rtl/gx_texture_detile_convert.sv
// Top level of the texture detiler: configuration port, result sequencer,
// palette read pipeline and output register. Depends on gxdc_pkg,
// gxdc_pal_mem and gxdc_walker.
`default_nettype none
// A texture request (one tiled halfword) yields up to four results, one per
// cycle while the receiver does not stall: i4/index4 requests have four
// pixels, i8/i4a4/index8 two, all other formats one, and a request whose
// pixels all lie outside the image still occupies its slots but gives no
// result. The result sequencer steps through the pixels of one request; the
// next request is accepted on the cycle of the current one's final slot, so
// requests flow back to back. Each slot passes a multiply stage for the
// destination index together with the palette read (synchronous memory),
// then the output register. A palette write request gives no result. The
// palette store holds 4096 entries that are undefined until written.
module gx_texture_detile_convert (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         command,
	input  wire  [11:0] palette_slot,
	input  wire  [15:0] palette_word,
	input  wire  [15:0] source_halfword,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [19:0] dest_index,
	output logic [31:0] pixel_value,
	output logic        merge_or,
	output logic [1:0]  status,
	output logic        last
);
	import gxdc_pkg::*;

	// configuration registers
	logic [3:0]       fmt_q;
	logic [DIM_W-1:0] width_q, height_q, w_sat, h_sat;
	logic [1:0]       pfmt_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_I4;
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			pfmt_q   <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_FORMAT: fmt_q    <= pwdata[3:0];
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				REG_PALFMT: pfmt_q   <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_FORMAT: prdata = {28'd0, fmt_q};
			REG_WIDTH:  prdata = {21'd0, width_q};
			REG_HEIGHT: prdata = {21'd0, height_q};
			REG_PALFMT: prdata = {30'd0, pfmt_q};
			default:    prdata = '0;
		endcase
	end

	// clamp oversized images
	assign w_sat = (width_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width_q;
	assign h_sat = (height_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height_q;

	// handshake and sequencer control
	logic  advance, finishing, take, tex_take, pal_take;
	logic  busy_q;
	logic [1:0] k_q;
	walk_t walk, work_q;
	logic [15:0] hw_q;

	assign advance   = !out_valid || !out_stall;
	assign finishing = busy_q && (k_q == work_q.last_k);
	assign in_stall  = !(advance && (!busy_q || finishing));
	assign take      = in_valid && !in_stall;
	assign tex_take  = take && command;
	assign pal_take  = take && !command;

	gxdc_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (cfg_wr),
		.step   (tex_take),
		.fmt    (fmt_q),
		.w      (w_sat),
		.h      (h_sat),
		.walk   (walk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (tex_take) begin
			busy_q <= 1'b1;
			k_q    <= '0;
		end else if (advance && busy_q) begin
			busy_q <= !finishing;
			k_q    <= k_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (tex_take) begin
			work_q <= walk;
			hw_q   <= source_halfword;
		end
	end

	// slot stage: destination index, raw value, palette address
	logic [23:0] prod;
	logic [23:0] lin;
	logic [19:0] idx_a;
	logic [15:0] raw_a;
	logic [3:0]  upper;
	logic [13:0] pal_idx;
	logic        beyond_a;

	always_comb begin
		prod = work_q.mrow * work_q.mwid;
		if (work_q.dxt) begin
			lin = ((prod + {11'd0, work_q.mcol}) << 2) + {22'd0, work_q.cit};
		end else begin
			lin = prod + {11'd0, work_q.mcol} + {22'd0, k_q};
		end
		idx_a = lin[19:0];

		case (work_q.last_k)
			2'd3:    raw_a = {12'd0, 4'(hw_q >> (4'd12 - {k_q, 2'b00}))};
			2'd1:    raw_a = {8'd0, k_q[0] ? hw_q[7:0] : hw_q[15:8]};
			default: raw_a = hw_q;
		endcase
		if (work_q.dxt) begin
			raw_a = (work_q.cit < 2'd2) ? {hw_q[7:0], hw_q[15:8]}
				: {rev_pairs(hw_q[15:8]), rev_pairs(hw_q[7:0])};
		end
		pal_idx  = raw_a[13:0];
		beyond_a = (pal_idx >= 14'(PAL_DEPTH));
		upper    = work_q.mask >> k_q;
	end

	logic [15:0] pal_rdata;

	gxdc_pal_mem u_pal (
		.clk   (clk),
		.we    (pal_take),
		.waddr (palette_slot[PAL_AW-1:0]),
		.wdata (palette_word),
		.re    (advance),
		.raddr (pal_idx[PAL_AW-1:0]),
		.rdata (pal_rdata)
	);

	logic        valid_s1, last_s1, beyond_s1, unsup_s1, pass_s1;
	logic [19:0] idx_s1;
	logic [15:0] raw_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= busy_q && upper[0];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			idx_s1    <= idx_a;
			raw_s1    <= raw_a;
			last_s1   <= (upper[3:1] == 3'd0);
			beyond_s1 <= beyond_a;
			unsup_s1  <= work_q.unsup;
			pass_s1   <= work_q.pass;
		end
	end

	// conversion into the output register
	logic [31:0] val_c, pal_val;
	logic [1:0]  st_c;
	logic        merge_c;

	always_comb begin
		pal_val = (pfmt_q == PFMT_RGB5A3) ? conv_rgb5a3(pal_rdata) : {16'd0, pal_rdata};
		val_c   = {16'd0, raw_s1};
		st_c    = ST_OK;
		merge_c = 1'b0;
		case (fmt_q)
			FMT_I4:     val_c = {24'd0, raw_s1[3:0], raw_s1[3:0]};
			FMT_RGB5A3: val_c = conv_rgb5a3(raw_s1);
			FMT_RGBA8: begin
				merge_c = pass_s1;
				val_c   = pass_s1 ? {16'd0, raw_s1} : {raw_s1, 16'd0};
			end
			FMT_IDX4, FMT_IDX8, FMT_IDX14: begin
				val_c = beyond_s1 ? 32'd0 : pal_val;
				st_c  = beyond_s1 ? ST_PALIDX : ST_OK;
			end
			default: ;
		endcase
		if (unsup_s1) begin
			val_c   = '0;
			st_c    = ST_UNSUP;
			merge_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dest_index  <= unsup_s1 ? 20'd0 : idx_s1;
			pixel_value <= val_c;
			merge_or    <= merge_c;
			status      <= st_c;
			last        <= last_s1;
		end
	end

	// the sequencer holds off new requests until its final slot
	a_busy_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !finishing) |-> in_stall)
		else $error("request accepted mid-sequence");

	a_unsup_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_UNSUP) |-> (last && pixel_value == 32'd0 && dest_index == 20'd0))
		else $error("unsupported-format result malformed");

	a_palidx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_PALIDX) |-> (pixel_value == 32'd0 && !merge_or))
		else $error("palette overflow result carries a value");

endmodule
`default_nettype wire

### rtl/gxdc_pal_mem.sv
// Palette store: single write port, one registered read port.
// Depends on gxdc_pkg.
`default_nettype none
module gxdc_pal_mem (
	input  wire                       clk,
	input  wire                       we,
	input  wire [gxdc_pkg::PAL_AW-1:0] waddr,
	input  wire [15:0]                wdata,
	input  wire                       re,
	input  wire [gxdc_pkg::PAL_AW-1:0] raddr,
	output logic [15:0]               rdata
);
	import gxdc_pkg::*;

	logic [15:0] mem_q [PAL_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

### rtl/gxdc_walker.sv
// Tile walker: tile and in-tile counters, per-request pixel coordinates
// and in-image mask. Depends on gxdc_pkg.
`default_nettype none
module gxdc_walker (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      clear,
	input  wire                      step,
	input  wire [3:0]                fmt,
	input  wire [gxdc_pkg::DIM_W-1:0] w,
	input  wire [gxdc_pkg::DIM_W-1:0] h,
	output gxdc_pkg::walk_t          walk
);
	import gxdc_pkg::*;

	logic [9:0] tile_col_q, tile_row_q;
	logic [2:0] row_q, col_q;
	logic       pass_q;

	logic [1:0]  tw_log, th_log, per_m1;
	logic        known, dxt;
	logic [12:0] x0, y;
	logic [12:0] bx, by;
	logic [DIM_W-1:0] bw, bh;
	logic [DIM_W:0] tiles_x, tiles_y;
	logic [9:0] n_tile_col, n_tile_row;
	logic [2:0] n_row, n_col;
	logic       n_pass, tile_done;
	logic [3:0] col_sum;

	always_comb begin
		known  = 1'b1;
		dxt    = 1'b0;
		tw_log = 2'd3;
		th_log = 2'd3;
		per_m1 = 2'd0;
		case (fmt)
			FMT_I4, FMT_IDX4: begin
				per_m1 = 2'd3;
			end
			FMT_I8, FMT_I4A4, FMT_IDX8: begin
				th_log = 2'd2;
				per_m1 = 2'd1;
			end
			FMT_I8A8, FMT_R5G6B5, FMT_RGB5A3, FMT_RGBA8, FMT_IDX14: begin
				tw_log = 2'd2;
				th_log = 2'd2;
			end
			FMT_DXT1: begin
				dxt = 1'b1;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	always_comb begin
		x0 = ({3'd0, tile_col_q} << tw_log) + {10'd0, col_q};
		y  = ({3'd0, tile_row_q} << th_log) + {10'd0, row_q};
		bx = {2'd0, tile_col_q, row_q[0]};
		by = {2'd0, tile_row_q, row_q[1]};
		bw = DIM_W'(({1'b0, w} + 12'd3) >> 2);
		bh = DIM_W'(({1'b0, h} + 12'd3) >> 2);

		walk        = '0;
		walk.last_k = per_m1;
		walk.dxt    = dxt;
		walk.cit    = col_q[1:0];
		walk.pass   = pass_q;
		if (!known) begin
			walk.unsup = 1'b1;
			walk.mask  = 4'b0001;
		end else if (dxt) begin
			walk.mrow    = by[11:0];
			walk.mwid    = {1'b0, bw};
			walk.mcol    = bx;
			walk.mask[0] = (bx < {2'd0, bw}) && (by < {2'd0, bh});
		end else begin
			walk.mrow = y[11:0];
			walk.mwid = {1'b0, w};
			walk.mcol = x0;
			for (int k = 0; k < 4; k++) begin
				walk.mask[k] = (2'(k) <= per_m1) && ((x0 + 13'(k)) < {2'd0, w})
					&& (y < {2'd0, h});
			end
		end
	end

	// Next counter values after one texture request.
	always_comb begin
		tiles_x = 12'(({1'b0, w} + (12'd1 << tw_log) - 12'd1) >> tw_log);
		tiles_y = 12'(({1'b0, h} + (12'd1 << th_log) - 12'd1) >> th_log);
		n_tile_col = tile_col_q;
		n_tile_row = tile_row_q;
		n_row      = row_q;
		n_col      = col_q;
		n_pass     = pass_q;
		tile_done  = 1'b0;
		col_sum    = {1'b0, col_q} + {2'd0, per_m1} + 4'd1;
		if (dxt) begin
			if (col_q[1:0] == 2'd3) begin
				n_col = 3'd0;
				if (row_q[1:0] == 2'd3) begin
					n_row     = 3'd0;
					tile_done = 1'b1;
				end else begin
					n_row = row_q + 3'd1;
				end
			end else begin
				n_col = col_q + 3'd1;
			end
		end else if (known) begin
			if (col_sum >= (4'd1 << tw_log)) begin
				n_col = 3'd0;
				if ({1'b0, row_q} + 4'd1 >= (4'd1 << th_log)) begin
					n_row = 3'd0;
					if (fmt == FMT_RGBA8 && !pass_q) begin
						n_pass = 1'b1;
					end else begin
						n_pass    = 1'b0;
						tile_done = 1'b1;
					end
				end else begin
					n_row = row_q + 3'd1;
				end
			end else begin
				n_col = col_sum[2:0];
			end
		end
		if (tile_done) begin
			if ({2'd0, tile_col_q} + 12'd1 >= tiles_x) begin
				n_tile_col = '0;
				n_tile_row = ({2'd0, tile_row_q} + 12'd1 >= tiles_y) ? '0 : tile_row_q + 10'd1;
			end else begin
				n_tile_col = tile_col_q + 10'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_col_q <= '0;
			tile_row_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
			pass_q     <= 1'b0;
		end else if (clear) begin
			tile_col_q <= '0;
			tile_row_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
			pass_q     <= 1'b0;
		end else if (step) begin
			tile_col_q <= n_tile_col;
			tile_row_q <= n_tile_row;
			row_q      <= n_row;
			col_q      <= n_col;
			pass_q     <= n_pass;
		end
	end
endmodule
`default_nettype wire

### tb/gxdc_checker.sv
// Result checker of the texture detiler: watches the request and result
// channels, predicts every result and compares. Depends on gxdc_pkg.
module gxdc_checker
	import gxdc_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	input  wire         in_valid,
	input  wire         in_stall,
	input  wire         command,
	input  wire  [11:0] palette_slot,
	input  wire  [15:0] palette_word,
	input  wire  [15:0] source_halfword,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire  [19:0] dest_index,
	input  wire  [31:0] pixel_value,
	input  wire         merge_or,
	input  wire  [1:0]  status,
	input  wire         last,
	output int          fail_count,
	output int          pending
);
	typedef struct packed {
		logic [19:0] idx;
		logic [31:0] val;
		logic        mrg;
		logic [1:0]  st;
		logic        lst;
	} pixel_t;

	pixel_t      pixel_q[$];
	logic [15:0] pal_mem[PAL_DEPTH];
	int unsigned t_col, t_row, r_in, c_in, pass_b;
	logic [3:0]  fmt;
	int unsigned img_w, img_h;
	logic [1:0]  pal_fmt;

	assign pending = pixel_q.size();

	function automatic logic [31:0] to_argb(logic [15:0] p);
		logic [7:0] a, r, g, b;
		if (p[15]) begin
			a = 8'hff;
			r = {p[14:10], 3'b0} | p[14:12];
			g = {p[9:5], 3'b0} | p[9:7];
			b = {p[4:0], 3'b0} | p[4:2];
		end else begin
			a = (p[14:12] << 5) | (p[14:12] << 2) | (p[14:12] >> 1);
			r = {p[11:8], p[11:8]};
			g = {p[7:4], p[7:4]};
			b = {p[3:0], p[3:0]};
		end
		return {a, r, g, b};
	endfunction

	function automatic logic [7:0] swap_pairs(logic [7:0] b);
		return {b[1:0], b[3:2], b[5:4], b[7:6]};
	endfunction

	function automatic logic [31:0] pal_read(int unsigned i, ref logic [1:0] st);
		if (i >= PAL_DEPTH) begin
			st = ST_PALIDX;
			return 0;
		end
		return (pal_fmt == PFMT_RGB5A3) ? to_argb(pal_mem[i]) : {16'b0, pal_mem[i]};
	endfunction

	task automatic advance_tile(int unsigned w, int unsigned h, int unsigned tw,
			int unsigned th);
		t_col++;
		if (t_col >= (w + tw - 1) / tw) begin
			t_col = 0;
			t_row++;
			if (t_row >= (h + th - 1) / th) t_row = 0;
		end
	endtask

	task automatic predict_halfword(logic [15:0] hw);
		int unsigned w, h, tw, th, per, x, y, v, sub, bx, by, bw, bh;
		pixel_t      p;
		int          n;
		logic [1:0]  st;
		n = 0;
		w = img_w > MAX_DIM ? MAX_DIM : img_w;
		h = img_h > MAX_DIM ? MAX_DIM : img_h;
		if (fmt == FMT_DXT1) begin
			sub = r_in & 3;
			bx = t_col * 2 + (sub & 1);
			by = t_row * 2 + (sub >> 1);
			bw = (w + 3) / 4;
			bh = (h + 3) / 4;
			if (bx < bw && by < bh) begin
				v = c_in < 2 ? {hw[7:0], hw[15:8]}
					: {swap_pairs(hw[15:8]), swap_pairs(hw[7:0])};
				p = '{idx: 20'((by * bw + bx) * 4 + c_in), val: v, mrg: 0, st: ST_OK,
					lst: 1};
				pixel_q.push_back(p);
			end
			c_in++;
			if (c_in >= 4) begin
				c_in = 0;
				r_in++;
				if (r_in >= 4) begin
					r_in = 0;
					advance_tile(w, h, 8, 8);
				end
			end
			return;
		end
		case (fmt)
			FMT_I4, FMT_IDX4: begin tw = 8; th = 8; per = 4; end
			FMT_I8, FMT_I4A4, FMT_IDX8: begin tw = 8; th = 4; per = 2; end
			FMT_I8A8, FMT_R5G6B5, FMT_RGB5A3, FMT_RGBA8, FMT_IDX14: begin
				tw = 4; th = 4; per = 1;
			end
			default: begin
				pixel_q.push_back('{idx: 0, val: 0, mrg: 0, st: ST_UNSUP, lst: 1});
				return;
			end
		endcase
		for (int k = 0; k < per; k++) begin
			x = t_col * tw + c_in + k;
			y = t_row * th + r_in;
			if (x >= w || y >= h) continue;
			st = ST_OK;
			p.mrg = 0;
			if (per == 4) v = (hw >> (12 - 4 * k)) & 4'hf;
			else if (per == 2) v = (hw >> (8 - 8 * k)) & 8'hff;
			else v = hw;
			case (fmt)
				FMT_I4: v = (v << 4) | v;
				FMT_RGB5A3: v = to_argb(v[15:0]);
				FMT_RGBA8: begin
					p.mrg = pass_b[0];
					if (!pass_b) v = v << 16;
				end
				FMT_IDX4, FMT_IDX8: v = pal_read(v, st);
				FMT_IDX14: v = pal_read(v & 16'h3fff, st);
				default: ;
			endcase
			p.idx = 20'(y * w + x);
			p.val = v;
			p.st = st;
			p.lst = 0;
			pixel_q.push_back(p);
			n++;
		end
		if (n > 0) pixel_q[$].lst = 1;
		c_in += per;
		if (c_in >= tw) begin
			c_in = 0;
			r_in++;
			if (r_in >= th) begin
				r_in = 0;
				if (fmt == FMT_RGBA8 && pass_b == 0) pass_b = 1;
				else begin
					pass_b = 0;
					advance_tile(w, h, tw, th);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t e;
		if (!arst_n) begin
			fail_count <= 0;
			pixel_q.delete();
			t_col = 0; t_row = 0; r_in = 0; c_in = 0; pass_b = 0;
			fmt = FMT_I4; img_w = 1; img_h = 1; pal_fmt = 0;
		end else begin
			// Compare the result against the oldest prediction first.
			if (out_valid && !out_stall) begin
				if (pixel_q.size() == 0) begin
					$display("%0t: unexpected result idx=%h val=%h", $time, dest_index,
						pixel_value);
					fail_count <= fail_count + 1;
				end else begin
					e = pixel_q.pop_front();
					if (e !== {dest_index, pixel_value, merge_or, status, last}) begin
						$display("%0t: mismatch exp idx=%h val=%h mrg=%b st=%0d last=%b",
							$time, e.idx, e.val, e.mrg, e.st, e.lst);
						$display("%0t:          act idx=%h val=%h mrg=%b st=%0d last=%b",
							$time, dest_index, pixel_value, merge_or, status, last);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (psel && penable && pwrite) begin
				case (paddr[3:2])
					REG_FORMAT: fmt = pwdata[3:0];
					REG_WIDTH:  img_w = pwdata[10:0];
					REG_HEIGHT: img_h = pwdata[10:0];
					default:    pal_fmt = pwdata[1:0];
				endcase
				t_col = 0; t_row = 0; r_in = 0; c_in = 0; pass_b = 0;
			end
			if (in_valid && !in_stall) begin
				if (!command) pal_mem[palette_slot] = palette_word;
				else predict_halfword(source_halfword);
			end
		end
	end
endmodule

### tb/tb_top.sv
// Stimulus and verdict of the texture detiler regression. Depends on
// gxdc_pkg, gx_texture_detile_convert and gxdc_checker.
module tb_top;
	import gxdc_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [3:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	wire  [31:0] prdata;
	wire         pready;
	logic        in_valid = 0;
	wire         in_stall;
	logic        command = 0;
	logic [11:0] palette_slot = 0;
	logic [15:0] palette_word = 0;
	logic [15:0] source_halfword = 0;
	wire         out_valid;
	logic        out_stall = 0;
	wire  [19:0] dest_index;
	wire  [31:0] pixel_value;
	wire         merge_or;
	wire  [1:0]  status;
	wire         last;
	int          fail_count, pending;
	int          cycles = 0;
	// Receiver hold-off request from stimulus, served by the stall process.
	bit          hold_req = 0;
	// Palette slots written so far; random texel content keeps indexed reads inside them.
	int unsigned pal_top = 0;

	always #1 clk = ~clk;

	gx_texture_detile_convert dut (.*);
	gxdc_checker chk (.*);

	// Abort on a run that never drains.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("gx_texture_detile_convert regression: fail");
			$finish;
		end
	end

	// Receiver stall pattern: random phases, quiet stretches, one long hold.
	initial begin
		int mode;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1;
				repeat (300) @(negedge clk);
				out_stall <= 0;
				hold_req = 0;
			end else begin
				mode = $urandom_range(0, 9);
				repeat ($urandom_range(1, 30)) begin
					out_stall <= (mode < 3) ? 0 : ($urandom_range(0, 9) < mode - 2);
					@(negedge clk);
				end
			end
		end
	end

	task automatic reg_write(logic [1:0] r, logic [31:0] d);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {r, 2'b00}; pwdata <= d;
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// Offer one request and hold it until accepted; random gap afterwards when gaps is set.
	task automatic send_req(logic cmd, logic [11:0] slot, logic [15:0] word,
			logic [15:0] hw, bit gaps);
		in_valid <= 1; command <= cmd; palette_slot <= slot;
		palette_word <= word; source_halfword <= hw;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic drain;
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic pal_fill(int unsigned cnt, bit gaps);
		for (int unsigned s = 0; s < cnt; s++)
			send_req(0, 12'(s), 16'($urandom), 16'($urandom), gaps);
		if (cnt > pal_top) pal_top = cnt;
	endtask

	task automatic setup(logic [3:0] f, int unsigned w, int unsigned h, logic [1:0] pf);
		drain();
		reg_write(REG_FORMAT, f);
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
		reg_write(REG_PALFMT, pf);
	endtask

	// Halfword content that keeps palette indices inside the loaded slots.
	function automatic logic [15:0] texel(logic [3:0] f);
		logic [15:0] r;
		r = 16'($urandom);
		if (f == FMT_IDX8) r = {8'($urandom_range(0, pal_top - 1)),
			8'($urandom_range(0, pal_top - 1))};
		else if (f == FMT_IDX14)
			r = {$urandom_range(0, 3) == 0 ? 2'b11 : 2'($urandom),
				14'($urandom_range(0, pal_top - 1))};
		return r;
	endfunction

	initial begin
		logic [3:0]  fmts[12];
		logic [3:0]  f;
		int unsigned w, h, n, sent;
		fmts = '{FMT_I4, FMT_I8, FMT_I4A4, FMT_I8A8, FMT_R5G6B5, FMT_RGB5A3,
			FMT_RGBA8, FMT_IDX4, FMT_IDX8, FMT_IDX14, FMT_DXT1, 4'd7};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed: load palette, then extremes and the special cases.
		pal_fill(256, 0);
		send_req(0, 12'hfff, 16'hffff, 0, 0);
		pal_top = 256;
		setup(FMT_I4, 5, 3, 0);
		send_req(1, 0, 0, 16'hffff, 0);
		send_req(1, 0, 0, 16'h0000, 0);
		send_req(1, 0, 0, 16'h1234, 0);
		setup(FMT_RGB5A3, 1, 1, 0);
		send_req(1, 0, 0, 16'h8000, 0);
		send_req(1, 0, 0, 16'h7fff, 0);
		setup(4'd15, 4, 4, 3);
		send_req(1, 0, 0, 16'hffff, 0);
		setup(FMT_IDX8, 1024, 2047, 2);
		send_req(1, 0, 0, 16'h00ff, 0);
		send_req(1, 0, 0, 16'h8001, 0);
		setup(FMT_IDX14, 3, 3, 1);
		send_req(1, 0, 0, 16'hc0ff, 0);
		send_req(1, 0, 0, 16'h0001, 0);
		send_req(1, 0, 0, 16'h3fff, 0);
		setup(FMT_DXT1, 5, 5, 0);
		send_req(1, 0, 0, 16'h1b2c, 0);
		send_req(1, 0, 0, 16'hffe4, 0);
		send_req(1, 0, 0, 16'h1be4, 0);
		send_req(1, 0, 0, 16'h00ff, 0);

		// Long receiver hold while requests keep coming.
		setup(FMT_I4, 64, 64, 0);
		hold_req = 1;
		repeat (20) send_req(1, 0, 0, 16'($urandom), 0);

		// Random phases: small images mostly, a few large ones.
		sent = 0;
		while (sent < 140) begin
			f = fmts[$urandom_range(0, 11)];
			if ($urandom_range(0, 9) == 0) begin
				w = $urandom_range(900, 2047); h = $urandom_range(900, 2047);
			end else begin
				w = $urandom_range(1, 20); h = $urandom_range(1, 20);
			end
			setup(f, w, h, 2'($urandom));
			if ($urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 40);
				pal_fill(n, 1);
				sent += n;
			end
			n = $urandom_range(10, 50);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 15) == 0)
					send_req(0, 12'($urandom_range(0, pal_top - 1)), 16'($urandom), 0, 1);
				else send_req(1, 0, 0, texel(f), 1);
			end
			sent += n;
		end
		drain();
		if (fail_count == 0) $display("gx_texture_detile_convert regression: pass");
		else $display("gx_texture_detile_convert regression: fail");
		$finish;
	end
endmodule
